// ----- sv/ffba_pkg.sv -----
// Shared constants and types for the first-fit block allocator.
package ffba_pkg;
   localparam int POOL_ENTRIES = 256;
   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam int OFF_W = 25;
   localparam int ADDR_W = 32;
   localparam int GRAN_BITS = 5;
   localparam logic [IDX_W-1:0] MARKER = '0;
   localparam logic [OFF_W-1:0] SIZE_RESET = 25'd2097152;
   // entry word: start, length, link
   localparam int ENT_W = OFF_W + OFF_W + IDX_W;

   typedef enum logic [0:0] {
      CSR_MEMORY_BEGIN = 1'b0,
      CSR_MEMORY_SIZE  = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_READ,
      ST_CHECK,
      ST_PREV,
      ST_FIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [OFF_W-1:0] length;
      logic [IDX_W-1:0] link;
   } entry_type;
endpackage

// ----- sv/ffba_ram.sv -----
// Generic single-port write, single-port read RAM with registered read data.
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- sv/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: list walk over a pool RAM.
//  channel | ports                                   | transfer
//  request | req_kind, req_request_size, req_free_address | start & !busy
//  result  | rsp_block_address, rsp_ok               | rsp_valid, one cycle
//  config  | csr_index, csr_data                     | csr_valid & csr_ready
// The accept cycle issues the head read; the first entry is checked next cycle and each
// further entry passes through a read state and a check state. An allocate then scans the
// in-use bits one per cycle; a predecessor link rewrite goes through the PREV and FIX
// states, the DONE state follows and the result shows the cycle after.
// Reset is synchronous; the pool RAM needs no clearing since only listed entries are
// read. The receiver cannot stall results.
module first_fit_block_allocator
   import ffba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  logic [OFF_W-1:0]  req_request_size,
   input  logic [ADDR_W-1:0] req_free_address,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_block_address,
   output logic              rsp_ok,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_data
);
   state_type state_ff, state_in;
   logic [ADDR_W-1:0] begin_ff;
   logic [OFF_W-1:0] size_ff;
   logic [POOL_ENTRIES-1:0] used_ff, used_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic kind_ff, kind_in;
   logic [OFF_W:0] need_ff, need_in;     // one extra bit: sizes up to 2^25-1 round up to 2^25 without overflow
   logic [ADDR_W-1:0] off_ff, off_in;
   logic [OFF_W:0] gap_ff, gap_in;       // running block end
   logic [IDX_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic at_head_ff, at_head_in;
   logic [IDX_W:0] scan_ff, scan_in;
   logic [IDX_W:0] steps_ff, steps_in;
   logic [IDX_W-1:0] nlink_ff, nlink_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data, ent;

   ffba_ram #(.WIDTH(ENT_W), .DEPTH(POOL_ENTRIES)) u_pool (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // marker start lives in a register so a size write moves it at once
   always_comb begin
      ent = rd_data;
      if (cur_ff == MARKER) begin
         ent.start = size_ff;
         ent.length = '0;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_block_address = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         begin_ff <= '0;
         size_ff <= SIZE_RESET;
         used_ff <= {{(POOL_ENTRIES-1){1'b0}}, 1'b1};
         head_ff <= MARKER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_MEMORY_BEGIN: begin_ff <= csr_data;
               CSR_MEMORY_SIZE:  size_ff <= csr_data[OFF_W-1:0];
               default: ;
            endcase
         end
      end
      kind_ff <= kind_in;
      need_ff <= need_in;
      off_ff <= off_in;
      gap_ff <= gap_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      at_head_ff <= at_head_in;
      scan_ff <= scan_in;
      steps_ff <= steps_in;
      nlink_ff <= nlink_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      head_in = head_ff;
      kind_in = kind_ff;
      need_in = need_ff;
      off_in = off_ff;
      gap_in = gap_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      at_head_in = at_head_ff;
      scan_in = scan_ff;
      steps_in = steps_ff;
      nlink_in = nlink_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in = rsp_ok_ff;
      rsp_addr_in = rsp_addr_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = rd_data;
      rd_addr = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = head_ff;
            if (start) begin
               kind_in = req_kind;
               need_in = ({1'b0, req_request_size} + 26'd31) &
                         ~((OFF_W+1)'(31));
               off_in = req_free_address - begin_ff;
               gap_in = '0;
               cur_in = head_ff;
               at_head_in = 1'b1;
               steps_in = '0;
               rsp_ok_in = 1'b0;
               rsp_addr_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_READ: begin
            // read issued last cycle address cur_ff; data is ready next
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (kind_ff == KIND_ALLOC) begin
               if ({1'b0, ent.start} >= gap_ff &&
                   ({1'b0, ent.start} - gap_ff) >= need_ff) begin
                  scan_in = '0;
                  state_in = ST_FIND;
               end else if (cur_ff == MARKER || steps_ff == (IDX_W+1)'(POOL_ENTRIES)) begin
                  state_in = ST_DONE;
               end else begin
                  gap_in = {1'b0, ent.start} + {1'b0, ent.length};
                  prev_in = cur_ff;
                  at_head_in = 1'b0;
                  cur_in = ent.link;
                  rd_addr = ent.link;
                  steps_in = steps_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               if (off_ff[ADDR_W-1:OFF_W] == '0 && ent.start == off_ff[OFF_W-1:0]) begin
                  if (cur_ff == MARKER) begin
                     state_in = ST_DONE;
                  end else begin
                     used_in[cur_ff] = 1'b0;
                     rsp_ok_in = 1'b1;
                     nlink_in = ent.link;
                     if (at_head_ff) begin
                        head_in = ent.link;
                        state_in = ST_DONE;
                     end else begin
                        rd_addr = prev_ff;
                        state_in = ST_PREV;
                     end
                  end
               end else if (cur_ff == MARKER || steps_ff == (IDX_W+1)'(POOL_ENTRIES)) begin
                  state_in = ST_DONE;
               end else begin
                  prev_in = cur_ff;
                  at_head_in = 1'b0;
                  cur_in = ent.link;
                  rd_addr = ent.link;
                  steps_in = steps_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FIND: begin
            // scan the in-use bits one per cycle for a free pool entry
            if (scan_ff == (IDX_W+1)'(POOL_ENTRIES)) begin
               state_in = ST_DONE;
            end else if (!used_ff[scan_ff[IDX_W-1:0]]) begin
               used_in[scan_ff[IDX_W-1:0]] = 1'b1;
               wr_en = 1'b1;
               wr_addr = scan_ff[IDX_W-1:0];
               wr_data.start = gap_ff[OFF_W-1:0];
               wr_data.length = need_ff[OFF_W-1:0];
               wr_data.link = cur_ff;
               rsp_ok_in = 1'b1;
               rsp_addr_in = begin_ff + ADDR_W'(gap_ff);
               nlink_in = scan_ff[IDX_W-1:0];
               if (at_head_ff) begin
                  head_in = scan_ff[IDX_W-1:0];
                  state_in = ST_DONE;
               end else begin
                  rd_addr = prev_ff;
                  state_in = ST_PREV;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_PREV: begin
            rd_addr = prev_ff;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // rewrite the predecessor's link
            wr_en = 1'b1;
            wr_addr = prev_ff;
            wr_data = rd_data;
            wr_data.link = nlink_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DONE) else $error("stray result");
   a_marker_used: assert property (@(posedge clock) disable iff (reset)
      used_ff[MARKER]) else $error("end marker released");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready) else $error("config accepted while busy");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_block_address == '0) else $error("bad fail addr");
`endif
endmodule

// ----- tb/sv/first_fit_block_allocator_tb.sv -----
// Testbench for the first-fit block allocator: scoreboard with list predictor, request driver.
module first_fit_block_allocator_tb;
   import ffba_pkg::*;

   class alloc_scoreboard;
      typedef struct {
         logic [ADDR_W-1:0] addr;
         logic              ok;
      } outcome_type;

      logic [ADDR_W-1:0] base;
      logic [OFF_W-1:0]  span;
      logic [OFF_W-1:0]  blk_start [POOL_ENTRIES];
      logic [OFF_W-1:0]  blk_len [POOL_ENTRIES];
      logic [IDX_W-1:0]  blk_link [POOL_ENTRIES];
      bit                taken [POOL_ENTRIES];
      logic [IDX_W-1:0]  head;
      outcome_type       pending [$];
      int                mismatches;

      function new();
         base = '0;
         span = SIZE_RESET;
         foreach (taken[i]) begin
            taken[i] = 1'b0;
            blk_start[i] = '0;
            blk_len[i] = '0;
            blk_link[i] = '0;
         end
         taken[MARKER] = 1'b1;
         blk_start[MARKER] = span;
         head = MARKER;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [ADDR_W-1:0] value);
         if (idx == CSR_MEMORY_BEGIN) begin
            base = value;
         end else begin
            span = value[OFF_W-1:0];
            blk_start[MARKER] = span;
         end
      endfunction

      function outcome_type allocate(logic [OFF_W-1:0] req);
         outcome_type res;
         int unsigned need, gap_lo, gap_hi, cur, prev, fresh;
         bit          at_head;
         need = (int'(req) + 31) & ~32'd31;
         gap_lo = 0;
         prev = 0;
         at_head = 1'b1;
         cur = head;
         res.addr = '0;
         res.ok = 1'b0;
         for (int steps = 0; steps <= POOL_ENTRIES; steps++) begin
            gap_hi = blk_start[cur];
            if (gap_hi >= gap_lo && gap_hi - gap_lo >= need) begin
               fresh = POOL_ENTRIES;
               for (int i = 0; i < POOL_ENTRIES; i++)
                  if (!taken[i] && fresh == POOL_ENTRIES) fresh = i;
               if (fresh == POOL_ENTRIES) return res;
               taken[fresh] = 1'b1;
               blk_start[fresh] = gap_lo[OFF_W-1:0];
               blk_len[fresh] = need[OFF_W-1:0];
               blk_link[fresh] = cur[IDX_W-1:0];
               if (at_head) head = fresh[IDX_W-1:0];
               else blk_link[prev] = fresh[IDX_W-1:0];
               res.addr = base + gap_lo;
               res.ok = 1'b1;
               return res;
            end
            if (cur == MARKER) return res;
            gap_lo = blk_start[cur] + blk_len[cur];
            prev = cur;
            at_head = 1'b0;
            cur = blk_link[cur];
         end
         return res;
      endfunction

      function outcome_type free_block(logic [ADDR_W-1:0] address);
         outcome_type       res;
         logic [ADDR_W-1:0] off;
         int unsigned       cur, prev;
         bit                at_head;
         off = address - base;
         prev = 0;
         at_head = 1'b1;
         cur = head;
         res.addr = '0;
         res.ok = 1'b0;
         for (int steps = 0; steps <= POOL_ENTRIES; steps++) begin
            if (ADDR_W'(blk_start[cur]) == off) begin
               if (cur == MARKER) return res;
               if (at_head) head = blk_link[cur];
               else blk_link[prev] = blk_link[cur];
               taken[cur] = 1'b0;
               res.ok = 1'b1;
               return res;
            end
            if (cur == MARKER) return res;
            prev = cur;
            at_head = 1'b0;
            cur = blk_link[cur];
         end
         return res;
      endfunction

      function void note_request(kind_type kind, logic [OFF_W-1:0] req,
                                 logic [ADDR_W-1:0] faddr);
         if (kind == KIND_ALLOC) pending.push_back(allocate(req));
         else pending.push_back(free_block(faddr));
      endfunction

      function void check_result(logic [ADDR_W-1:0] addr, logic ok);
         outcome_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: addr %h ok %b", addr, ok);
            return;
         end
         want = pending.pop_front();
         if (addr !== want.addr || ok !== want.ok) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected addr %h ok %b, got addr %h ok %b",
                        want.addr, want.ok, addr, ok);
         end
      endfunction

      // pick the absolute address of a random listed block, or noise if none
      function logic [ADDR_W-1:0] live_address();
         logic [ADDR_W-1:0] found [$];
         int unsigned       cur;
         cur = head;
         for (int steps = 0; steps <= POOL_ENTRIES && cur != MARKER; steps++) begin
            found.push_back(base + blk_start[cur]);
            cur = blk_link[cur];
         end
         if (found.size() == 0) return $urandom;
         return found[$urandom_range(0, found.size() - 1)];
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_kind = 1'b0;
   logic [OFF_W-1:0]  req_request_size = '0;
   logic [ADDR_W-1:0] req_free_address = '0;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_block_address;
   logic              rsp_ok;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [ADDR_W-1:0] csr_data = '0;

   alloc_scoreboard board = new();
   bit              gaps_on = 1'b1;

   first_fit_block_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_request_size(req_request_size),
      .req_free_address(req_free_address), .rsp_valid(rsp_valid),
      .rsp_block_address(rsp_block_address), .rsp_ok(rsp_ok),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_block_address, rsp_ok);
   end

   task automatic send_item(kind_type kind, logic [OFF_W-1:0] req,
                            logic [ADDR_W-1:0] faddr);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_request_size <= req;
      req_free_address <= faddr;
      do @(posedge clock); while (busy);
      board.note_request(kind, req, faddr);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_items(int count, int unsigned size_cap);
      logic [OFF_W-1:0] req;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 6) begin
            if ($urandom_range(0, 19) == 0) req = OFF_W'($urandom);
            else req = OFF_W'($urandom_range(0, size_cap));
            send_item(KIND_ALLOC, req, $urandom);
         end else if ($urandom_range(0, 9) < 8) begin
            send_item(KIND_FREE, OFF_W'($urandom), board.live_address());
         end else begin
            send_item(KIND_FREE, OFF_W'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: size extremes, rounding, free of marker, unknown and far offsets
      write_reg(CSR_MEMORY_BEGIN, 32'h1000_0000);
      write_reg(CSR_MEMORY_SIZE, 32'd16777216);
      send_item(KIND_ALLOC, 25'd0, '0);
      send_item(KIND_ALLOC, 25'd1, '1);
      send_item(KIND_ALLOC, 25'd31, '0);
      send_item(KIND_ALLOC, 25'd32, '0);
      send_item(KIND_ALLOC, 25'd33, '0);
      send_item(KIND_ALLOC, 25'd16777216, '0);
      send_item(KIND_ALLOC, 25'h1FF_FFFF, '0);
      send_item(KIND_ALLOC, 25'd8388608, '0);
      send_item(KIND_FREE, '1, 32'h1000_0000 + 32'd16777216);
      send_item(KIND_FREE, '0, 32'h1000_0010);
      send_item(KIND_FREE, '0, 32'h1200_0000);
      send_item(KIND_FREE, '0, 32'h0FFF_FFE0);
      send_item(KIND_FREE, '0, 32'h1000_0000);
      send_item(KIND_FREE, '0, 32'h1000_0020);
      send_item(KIND_FREE, '0, 32'h1000_0000);
      send_item(KIND_ALLOC, 25'd64, '0);
      settle();

      // empty memory, then lower the size under listed blocks
      write_reg(CSR_MEMORY_SIZE, '0);
      send_item(KIND_ALLOC, 25'd0, '0);
      send_item(KIND_ALLOC, 25'd1, '0);
      send_item(KIND_FREE, '0, board.live_address());
      settle();

      write_reg(CSR_MEMORY_BEGIN, 32'h8000_0000);
      write_reg(CSR_MEMORY_SIZE, 32'd4096);
      random_items(200, 300);
      settle();
      write_reg(CSR_MEMORY_SIZE, 32'd1024);
      random_items(150, 200);
      settle();

      // large memory with tiny blocks fills the pool
      write_reg(CSR_MEMORY_BEGIN, 32'hFFFF_FFE0);
      write_reg(CSR_MEMORY_SIZE, 32'd16777216);
      for (int n = 0; n < 300; n++)
         send_item(KIND_ALLOC, OFF_W'($urandom_range(0, 64)), $urandom);
      random_items(200, 100000);
      settle();

      write_reg(CSR_MEMORY_BEGIN, $urandom);
      write_reg(CSR_MEMORY_SIZE, $urandom_range(0, 16777216));
      random_items(200, 20000);
      settle();

      gaps_on = 1'b0;
      write_reg(CSR_MEMORY_BEGIN, 32'h0000_0000);
      write_reg(CSR_MEMORY_SIZE, 32'd2097152);
      random_items(200, 8192);
      settle();

      if (board.mismatches == 0 && board.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #80000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- files.f -----
sv/ffba_pkg.sv
sv/ffba_ram.sv
sv/first_fit_block_allocator.sv
tb/sv/first_fit_block_allocator_tb.sv
